// ===== hdl/kfe_pkg.sv =====
`default_nettype none

package kfe_pkg;

	localparam int OPCODE_W = 2;
	localparam int DIGIT_W  = 4;
	localparam int KIND_W   = 2;
	localparam int FREQ_W   = 54;
	localparam int CHAR_W   = 4;
	localparam int LEN_W    = 4;
	localparam int VALUE_W  = 34;
	localparam int TICK_W   = 16;
	localparam int SCALE_W  = 20;
	localparam int CFG_IDX_W = 1;

	localparam logic [LEN_W-1:0]   MAX_CHARS      = 4'd11;
	localparam logic [LEN_W-1:0]   DOT_MAX_LENGTH = 4'd4;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX      = 4'd9;
	localparam logic [CHAR_W-1:0]  CHAR_DOT       = 4'd10;

	localparam logic [TICK_W-1:0] ENTRY_TIMEOUT_RST = 16'd5000;
	localparam logic [TICK_W-1:0] FULL_TIMEOUT_RST  = 16'd500;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_TIMEOUT  = 1'b1;

	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef enum logic [OPCODE_W-1:0] {
		OP_DIGIT = 2'd0,
		OP_DOT   = 2'd1,
		OP_ENTER = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		EV_SHOW     = 2'd0,
		EV_SET_FREQ = 2'd1,
		EV_RESET    = 2'd2
	} event_kind_t;

	// one queued entry; a set-frequency entry expands to two items on the way out
	typedef struct packed {
		event_kind_t        kind;
		logic [FREQ_W-1:0]  freq;
		logic [CHAR_W-1:0]  ch;
		logic [LEN_W-1:0]   len;
	} rq_entry_t;

	// ten to the power (6 - fraction digits), 1 when the exponent is zero or negative
	function automatic logic [SCALE_W-1:0] pow10_scale(input logic [LEN_W-1:0] frac);
		logic [SCALE_W-1:0] s;
		case (frac)
			4'd0:    s = 20'd1000000;
			4'd1:    s = 20'd100000;
			4'd2:    s = 20'd10000;
			4'd3:    s = 20'd1000;
			4'd4:    s = 20'd100;
			4'd5:    s = 20'd10;
			default: s = 20'd1;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/kfe_if.sv =====
`default_nettype none

interface kfe_key_if
	import kfe_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [DIGIT_W-1:0]  digit;

	modport source (output valid, output opcode, output digit, input ready);
	modport sink   (input valid, input opcode, input digit, output ready);
endinterface

interface kfe_event_if
	import kfe_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	logic [FREQ_W-1:0] frequency_hz;
	logic [CHAR_W-1:0] appended_char;
	logic [LEN_W-1:0]  entry_length;
	logic              last;

	modport source (output valid, output event_kind, output frequency_hz,
		output appended_char, output entry_length, output last, input ready);
	modport sink   (input valid, input event_kind, input frequency_hz,
		input appended_char, input entry_length, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/kfe_rq.sv =====
`default_nettype none

module kfe_rq
	import kfe_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire rq_entry_t push_entry,
	output logic           space,
	kfe_event_if.source    events
);

	rq_entry_t             mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]   wr_ptr_q;
	logic [RQ_PTR_W-1:0]   rd_ptr_q;
	logic [RQ_CNT_W-1:0]   cnt_q;
	logic                  phase_q;
	rq_entry_t             head;
	logic                  pair_first;
	logic                  take;
	logic                  pop;

	assign head       = mem_q[rd_ptr_q];
	assign pair_first = (head.kind == EV_SET_FREQ) && !phase_q;
	assign take       = events.valid && events.ready;
	assign pop        = take && !pair_first;
	assign space      = cnt_q < RQ_CNT_W'(RQ_DEPTH);

	assign events.valid         = cnt_q != '0;
	assign events.event_kind    = (head.kind == EV_SET_FREQ && phase_q) ? EV_RESET : head.kind;
	assign events.frequency_hz  = phase_q ? '0 : head.freq;
	assign events.appended_char = head.ch;
	assign events.entry_length  = head.len;
	assign events.last          = !pair_first;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (take) begin
				phase_q <= pair_first;
			end
			cnt_q <= cnt_q + RQ_CNT_W'(push) - RQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/keypad_frequency_entry_unit.sv =====
`default_nettype none
// a key item is captured in the input stage register; once the queue has room its result
// is written into the result queue, which drives the output; one key item per cycle while
// the queue has room; an enter emits two result items, set frequency then display reset
// a four-entry result queue decouples the input stage from output stalls
// reset (arst_n low): entry cleared, timer stopped, queue emptied,
// timeouts back to 5000 and 500 ticks

module keypad_frequency_entry_unit
	import kfe_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [TICK_W-1:0]     cfg_wdata,
	kfe_key_if.sink                    keys,
	kfe_event_if.source                events
);

	// configuration
	logic [TICK_W-1:0] entry_timeout_q;
	logic [TICK_W-1:0] full_timeout_q;

	// input stage
	logic               valid_s1;
	op_t                op_s1;
	logic [DIGIT_W-1:0] digit_s1;
	logic               adv;

	// entry state
	logic [VALUE_W-1:0] value_q, value_d;
	logic [LEN_W-1:0]   cnt_q, cnt_d;
	logic               dot_q, dot_d;
	logic [LEN_W-1:0]   frac_q, frac_d;
	logic [TICK_W-1:0]  timer_q, timer_d;
	logic               running_q, running_d;

	// result path
	logic               push;
	rq_entry_t          push_entry;
	logic               space;
	logic [FREQ_W-1:0]  product;
	logic [LEN_W-1:0]   cnt_inc;

	// process the held item only when the queue can take an entry
	assign adv        = valid_s1 && space;
	assign keys.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_timeout_q <= ENTRY_TIMEOUT_RST;
			full_timeout_q  <= FULL_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_TIMEOUT: entry_timeout_q <= cfg_wdata;
				REG_FULL_TIMEOUT:  full_timeout_q  <= cfg_wdata;
				default:           entry_timeout_q <= entry_timeout_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (keys.ready) begin
			valid_s1 <= keys.valid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (keys.ready && keys.valid) begin
			op_s1    <= op_t'(keys.opcode);
			digit_s1 <= keys.digit;
		end
	end

	// frequency in hz: typed digits times a power of ten from the table
	assign product = FREQ_W'(value_q) * FREQ_W'(pow10_scale(frac_q));
	assign cnt_inc = cnt_q + 1'b1;

	always_comb begin
		value_d    = value_q;
		cnt_d      = cnt_q;
		dot_d      = dot_q;
		frac_d     = frac_q;
		timer_d    = timer_q;
		running_d  = running_q;
		push       = 1'b0;
		push_entry = '{kind: EV_SHOW, freq: '0, ch: '0, len: '0};
		case (op_s1)
			OP_DIGIT: begin
				// out-of-range digits are dropped without touching the timer
				if (digit_s1 <= DIGIT_MAX) begin
					timer_d   = entry_timeout_q;
					running_d = 1'b1;
					if (cnt_q < MAX_CHARS) begin
						value_d = (value_q << 3) + (value_q << 1) + VALUE_W'(digit_s1);
						cnt_d   = cnt_inc;
						if (dot_q) begin
							frac_d = frac_q + 1'b1;
						end
						push       = 1'b1;
						push_entry = '{kind: EV_SHOW, freq: '0, ch: digit_s1, len: cnt_inc};
					end
				end
			end
			OP_DOT: begin
				timer_d   = entry_timeout_q;
				running_d = 1'b1;
				// only one dot, and only early enough in the entry
				if (cnt_q < MAX_CHARS && !dot_q && cnt_q <= DOT_MAX_LENGTH) begin
					dot_d      = 1'b1;
					cnt_d      = cnt_inc;
					push       = 1'b1;
					push_entry = '{kind: EV_SHOW, freq: '0, ch: CHAR_DOT, len: cnt_inc};
				end
			end
			OP_ENTER: begin
				timer_d   = full_timeout_q;
				running_d = 1'b1;
				// a full entry just rearms the short timer and stays
				if (cnt_q < MAX_CHARS) begin
					value_d    = '0;
					cnt_d      = '0;
					dot_d      = 1'b0;
					frac_d     = '0;
					timer_d    = '0;
					running_d  = 1'b0;
					push       = 1'b1;
					push_entry = '{kind: EV_SET_FREQ, freq: product, ch: '0, len: '0};
				end
			end
			OP_TICK: begin
				if (running_q) begin
					if (timer_q <= TICK_W'(1)) begin
						// timeout: abandon the entry
						timer_d    = '0;
						running_d  = 1'b0;
						value_d    = '0;
						cnt_d      = '0;
						dot_d      = 1'b0;
						frac_d     = '0;
						push       = 1'b1;
						push_entry = '{kind: EV_RESET, freq: '0, ch: '0, len: '0};
					end else begin
						timer_d = timer_q - 1'b1;
					end
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
		if (!adv) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q   <= '0;
			cnt_q     <= '0;
			dot_q     <= 1'b0;
			frac_q    <= '0;
			timer_q   <= '0;
			running_q <= 1'b0;
		end else if (adv) begin
			value_q   <= value_d;
			cnt_q     <= cnt_d;
			dot_q     <= dot_d;
			frac_q    <= frac_d;
			timer_q   <= timer_d;
			running_q <= running_d;
		end
	end

	kfe_rq u_rq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.space      (space),
		.events     (events)
	);

`ifndef ASSERT_OFF
	// an item that is not the last of its input is always the set-frequency half of an enter
	a_not_last_is_freq: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && !events.last |-> events.event_kind == EV_SET_FREQ)
		else $error("non-final result item is not set frequency");

	// the display reset follows a taken set-frequency item right away
	a_reset_follows_freq: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.ready && !events.last
		|=> events.valid && events.event_kind == EV_RESET && events.last)
		else $error("display reset missing after set frequency");

	// the queue is never written without room
	a_push_has_space: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("result queue overrun");

	// a stopped timer holds zero count
	a_timer_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> timer_q == '0)
		else $error("stopped timer holds a count");
`endif

endmodule

`default_nettype wire
